>>> rtl/bsc_pkg.sv
// Shared types and constants for the banker safety check block.
package bsc_pkg;

    localparam int MAX_CLIENTS_DEF = 16;
    localparam int NUM_RES_DEF     = 3;
    localparam int RES_W           = 8;   // need, held and avail width
    localparam int WORK_W          = 16;  // saturating work counter width
    localparam int IDX_W           = 4;   // client index and pick field width
    localparam int ACTIVE_W        = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int PORT_RES        = 3;   // resources carried on the input ports
    localparam int ROW_W_DEF       = 2 * NUM_RES_DEF * RES_W;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
    localparam logic [WORK_W-1:0]   WORK_MAX     = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVAIL_CPU     = 2'd0,
        CFG_AVAIL_MEM     = 2'd1,
        CFG_AVAIL_STORAGE = 2'd2,
        CFG_ACTIVE        = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_VERDICT
    } t_state;

endpackage

>>> rtl/banker_safety_check.sv
// Top level of the banker safety check: row loading, scan sequencer, result register.
//
// Input channel (i_in_valid / o_in_ready): one client row per transfer, index,
// need and allocation for three resources. Rows load at one per cycle while
// the block is idle. A row with i_final_row set is stored and starts the check.
// Output channel (o_out_valid / i_out_ready): one result per client picked in
// the safe order, then a verdict (is_verdict=1, end_of_run=1, safe set or not).
// Configuration port: i_cfg_we with i_cfg_index 0..2 writes the available
// units, index 3 the active client count; write only while idle.
// Scan: each examined row takes a memory read, then a compare and update, in
// the row store's single read port. A pass scans from client 0 and ends at
// the first fit, or with an unsafe verdict when no unfinished client fits.
// Receiver stalls lengthen a check. The first pick passes the READ and EVAL
// states after the final row transfer before it enters the output register.
// o_in_ready is low from the final row until the verdict enters the output
// register; a stalled receiver holds the scan at the next pick or verdict.
// Reset clears the available units, sets the active count to 16, and clears the
// sequencer and output valid flag; the row store is not cleared and rows must be written before a check reads them.
module banker_safety_check #(
    parameter int MAX_CLIENTS   = bsc_pkg::MAX_CLIENTS_DEF,
    parameter int NUM_RESOURCES = bsc_pkg::NUM_RES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bsc_pkg::IDX_W-1:0]    i_client_index,
    input  logic [bsc_pkg::RES_W-1:0]    i_need_cpu,
    input  logic [bsc_pkg::RES_W-1:0]    i_need_mem,
    input  logic [bsc_pkg::RES_W-1:0]    i_need_storage,
    input  logic [bsc_pkg::RES_W-1:0]    i_held_cpu,
    input  logic [bsc_pkg::RES_W-1:0]    i_held_mem,
    input  logic [bsc_pkg::RES_W-1:0]    i_held_storage,
    input  logic                         i_final_row,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bsc_pkg::IDX_W-1:0]    o_picked_client,
    output logic                         o_is_verdict,
    output logic                         o_safe,
    output logic                         o_end_of_run
);
    import bsc_pkg::*;

    localparam int CW    = $clog2(MAX_CLIENTS);
    localparam int NW    = $clog2(MAX_CLIENTS + 1);
    localparam int HALF  = NUM_RESOURCES * RES_W;
    localparam int ROW_W = 2 * HALF;

    // configuration
    logic [RES_W-1:0]    r_avail [PORT_RES];
    logic [ACTIVE_W-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail[0] <= '0;
            r_avail[1] <= '0;
            r_avail[2] <= '0;
            r_active   <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AVAIL_CPU:     r_avail[0] <= i_cfg_data;
                CFG_AVAIL_MEM:     r_avail[1] <= i_cfg_data;
                CFG_AVAIL_STORAGE: r_avail[2] <= i_cfg_data;
                CFG_ACTIVE:        r_active   <= i_cfg_data[ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective client count, clamped to the table depth
    logic [NW-1:0] w_n;
    assign w_n = (int'(r_active) > MAX_CLIENTS) ? NW'(MAX_CLIENTS) : NW'(r_active);

    // sequencer state
    t_state                  r_state, n_state;
    logic [CW-1:0]           r_c;
    logic [NW-1:0]           r_cnt;
    logic [MAX_CLIENTS-1:0]  r_fin;
    logic                    r_safe_pend;
    logic [NUM_RESOURCES-1:0][WORK_W-1:0] r_work;

    logic r_out_valid;
    logic [IDX_W-1:0] r_pick;
    logic r_verd, r_safe, r_end;

    logic w_in_xfer, w_start, w_row_ok, w_slot_free;
    logic w_cand, w_pick_fire, w_verd_fire, w_ram_re;
    logic [NW-1:0] w_c_next, w_cnt_next;

    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_start     = w_in_xfer && i_final_row;
    assign w_row_ok    = int'(i_client_index) < MAX_CLIENTS;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_c_next    = NW'(r_c) + NW'(1);
    assign w_cnt_next  = r_cnt + NW'(1);

    // row packing: need in the low half, allocation in the high half
    logic [RES_W-1:0] w_need_in [PORT_RES];
    logic [RES_W-1:0] w_held_in [PORT_RES];
    logic [ROW_W-1:0] w_wrow, w_rrow;

    assign w_need_in[0] = i_need_cpu;
    assign w_need_in[1] = i_need_mem;
    assign w_need_in[2] = i_need_storage;
    assign w_held_in[0] = i_held_cpu;
    assign w_held_in[1] = i_held_mem;
    assign w_held_in[2] = i_held_storage;

    logic [NUM_RESOURCES-1:0]             w_fit;
    logic [NUM_RESOURCES-1:0][WORK_W-1:0] w_work_sat, w_work_init;

    for (genvar r = 0; r < NUM_RESOURCES; r++) begin : g_res
        logic [RES_W-1:0]  w_need, w_held;
        logic [WORK_W:0]   w_sum;

        if (r < PORT_RES) begin : g_port
            assign w_wrow[r*RES_W +: RES_W]        = w_need_in[r];
            assign w_wrow[HALF + r*RES_W +: RES_W] = w_held_in[r];
            assign w_work_init[r]                  = WORK_W'(r_avail[r]);
        end else begin : g_pad
            assign w_wrow[r*RES_W +: RES_W]        = '0;
            assign w_wrow[HALF + r*RES_W +: RES_W] = '0;
            assign w_work_init[r]                  = '0;
        end

        assign w_need        = w_rrow[r*RES_W +: RES_W];
        assign w_held        = w_rrow[HALF + r*RES_W +: RES_W];
        assign w_fit[r]      = WORK_W'(w_need) <= r_work[r];
        assign w_sum         = {1'b0, r_work[r]} + (WORK_W + 1)'(w_held);
        assign w_work_sat[r] = w_sum[WORK_W] ? WORK_MAX : w_sum[WORK_W-1:0];
    end

    bsc_row_ram #(
        .DEPTH (MAX_CLIENTS),
        .WIDTH (ROW_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_xfer && w_row_ok),
        .i_waddr (CW'(i_client_index)),
        .i_wdata (w_wrow),
        .i_re    (w_ram_re),
        .i_raddr (r_c),
        .o_rdata (w_rrow)
    );

    assign w_cand = !r_fin[r_c] && (&w_fit);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = (w_n == '0) ? S_VERDICT : S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_cand) begin
                    if (w_slot_free) begin
                        n_state = (w_cnt_next == w_n) ? S_VERDICT : S_READ;
                    end
                end else begin
                    n_state = (w_c_next == w_n) ? S_VERDICT : S_READ;
                end
            end
            S_VERDICT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready  = 1'b0;
        w_ram_re    = 1'b0;
        w_pick_fire = 1'b0;
        w_verd_fire = 1'b0;
        case (r_state)
            S_IDLE:    o_in_ready  = 1'b1;
            S_READ:    w_ram_re    = 1'b1;
            S_EVAL:    w_pick_fire = w_cand && w_slot_free;
            S_VERDICT: w_verd_fire = w_slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_c         <= '0;
            r_cnt       <= '0;
            r_fin       <= '0;
            r_safe_pend <= 1'b0;
            r_work      <= '0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_c         <= '0;
                r_cnt       <= '0;
                r_fin       <= '0;
                r_safe_pend <= 1'b1;
                r_work      <= w_work_init;
            end else if (w_pick_fire) begin
                r_c        <= '0;
                r_cnt      <= w_cnt_next;
                r_fin[r_c] <= 1'b1;
                r_work     <= w_work_sat;
            end else if (r_state == S_EVAL && !w_cand) begin
                // no fit here: move on, or the pass ends unsafe
                r_c <= w_c_next[CW-1:0];
                if (w_c_next == w_n) begin
                    r_safe_pend <= 1'b0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pick_fire || w_verd_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pick_fire) begin
            r_pick <= IDX_W'(r_c);
            r_verd <= 1'b0;
            r_safe <= 1'b0;
            r_end  <= 1'b0;
        end else if (w_verd_fire) begin
            r_pick <= '0;
            r_verd <= 1'b1;
            r_safe <= r_safe_pend;
            r_end  <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_picked_client = r_pick;
    assign o_is_verdict    = r_verd;
    assign o_safe          = r_safe;
    assign o_end_of_run    = r_end;

`ifndef SYNTHESIS
    a_verdict_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_verd_fire |=> o_in_ready)
        else $error("sequencer did not return to idle after the verdict");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt <= w_n))
        else $error("pick count passed the active client count");

    a_fin_matches_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ($countones(r_fin) == int'(r_cnt)))
        else $error("finished mask disagrees with pick count");

    a_pick_marks_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pick_fire |=> r_fin[$past(r_c)])
        else $error("picked client not marked finished");
`endif

endmodule

>>> rtl/bsc_row_ram.sv
// Client row store: one write port, one registered read port.
module bsc_row_ram #(
    parameter int DEPTH = bsc_pkg::MAX_CLIENTS_DEF,
    parameter int WIDTH = bsc_pkg::ROW_W_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import bsc_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
